// File: hw/rtl/tlbpt_pkg.sv
// tlbpt_pkg: shared constants for the TLB / page table translator.
// No dependencies; imported by the top level and its checker.
`default_nettype none
package tlbpt_pkg;

  // outcome codes
  localparam logic [1:0] OUT_TLB_HIT   = 2'd0;
  localparam logic [1:0] OUT_PT_HIT    = 2'd1;
  localparam logic [1:0] OUT_FAULT     = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_POLICY    = 2'd0;
  localparam logic [1:0] CFG_FRAMES    = 2'd1;

  localparam int unsigned CFG_DATA_W   = 9;
  localparam int unsigned FRAMES_RESET = 256;

  localparam logic POL_FIFO = 1'b0;
  localparam logic POL_LRU  = 1'b1;

endpackage
`default_nettype wire

// File: hw/rtl/tlb_page_table_translator.sv
// tlb_page_table_translator: demand-paged address translation, TLB plus page table.
// Depends on tlbpt_pkg.
`default_nettype none
// A 16-bit virtual address (page in the upper byte, offset in the lower)
// is looked up in a fully associative TLB held in flops, then in a page
// table held in a synchronous RAM. On a fault a victim frame is chosen by
// FIFO order or, with policy = 1, by the largest LRU age (lowest frame on
// ties); the victim's old mapping and TLB entries are dropped and the new
// page is mapped there. Every TLB fill replaces in FIFO order. One result
// per address; no new address is taken while one is in progress. Under
// FIFO a hit goes from the lookup to the result; a fault passes through
// victim, owner read, an old-mapping check if the victim frame was owned,
// and map. Under LRU every access adds an age update sweep over the frames
// in use through the age RAM, and a fault adds a victim scan over them, so
// the age RAM port sets the rate there. After reset a clearing pass over
// max(PAGE_COUNT, MAX_FRAMES) entries initialises the page table, owner and
// age RAMs; no address is taken during it, configuration writes are.
// Configuration must be written only while the block is idle (unchecked).
module tlb_page_table_translator
  import tlbpt_pkg::*;
#(
  parameter int unsigned TLB_ENTRIES = 16,
  parameter int unsigned PAGE_COUNT  = 256,
  parameter int unsigned MAX_FRAMES  = 256,
  parameter int unsigned AGE_BITS    = 32
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  // configuration
  input  wire logic                  cfg_write,
  input  wire logic [1:0]            cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  // address channel
  input  wire logic                  addr_valid,
  output logic                       addr_ready,
  input  wire logic [15:0]           virtual_address,
  // result channel
  output logic                       result_valid,
  input  wire logic                  result_ready,
  output logic [7:0]                 frame_number,
  output logic [15:0]                physical_address,
  output logic [1:0]                 outcome,
  output logic [31:0]                tlb_hit_count,
  output logic [31:0]                fault_count
);

  localparam int unsigned PW    = $clog2(PAGE_COUNT);
  localparam int unsigned FW    = $clog2(MAX_FRAMES);
  localparam int unsigned NW    = $clog2(MAX_FRAMES + 1);
  localparam int unsigned TW    = $clog2(TLB_ENTRIES);
  localparam int unsigned DEPTH = (PAGE_COUNT > MAX_FRAMES) ? PAGE_COUNT : MAX_FRAMES;
  localparam int unsigned CW    = $clog2(DEPTH);

  localparam logic [3:0] S_CLR   = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_LOOK  = 4'd2;
  localparam logic [3:0] S_SCAN  = 4'd3;
  localparam logic [3:0] S_VICT  = 4'd4;
  localparam logic [3:0] S_OWN   = 4'd5;
  localparam logic [3:0] S_PMCHK = 4'd6;
  localparam logic [3:0] S_MAP   = 4'd7;
  localparam logic [3:0] S_AGEZ  = 4'd8;
  localparam logic [3:0] S_AGEUP = 4'd9;
  localparam logic [3:0] S_FIN   = 4'd10;

  logic [3:0]            state;
  logic                  policy;
  logic [CFG_DATA_W-1:0] frames_in_use;

  // TLB in flops
  logic          tlb_vld [TLB_ENTRIES];
  logic [PW-1:0] tlb_pg  [TLB_ENTRIES];
  logic [FW-1:0] tlb_fr  [TLB_ENTRIES];
  logic [TW-1:0] tlb_nx;

  logic [PW-1:0]       page_q;
  logic [PW-1:0]       old_q;
  logic [7:0]          off_q;
  logic [FW-1:0]       frm;
  logic [1:0]          outc;
  logic [NW-1:0]       k;
  logic [NW-1:0]       km1;
  logic [AGE_BITS-1:0] best;
  logic [FW-1:0]       frame_nx;
  logic [31:0]         hit_cnt;
  logic [31:0]         flt_cnt;
  logic [CW-1:0]       clr;

  // RAMs
  logic [FW:0]         pm_mem  [PAGE_COUNT];
  logic [PW:0]         own_mem [MAX_FRAMES];
  logic [AGE_BITS-1:0] age_mem [MAX_FRAMES];

  logic [FW:0]         pm_rd;
  logic [PW:0]         own_rd;
  logic [AGE_BITS-1:0] age_rd;

  logic                pm_we,  own_we,  age_we;
  logic [PW-1:0]       pm_raddr, pm_waddr;
  logic [FW-1:0]       own_waddr, age_waddr;
  logic [FW:0]         pm_wdata;
  logic [PW:0]         own_wdata;
  logic [AGE_BITS-1:0] age_wdata;

  logic [NW-1:0] n;
  logic [31:0]   fiu32;
  logic [PW-1:0] pg_in;
  logic          tlb_hit;
  logic [FW-1:0] tlb_hit_fr;
  logic [FW-1:0] fifo_v;
  logic [31:0]   frame32;
  logic          out_free;

  // usable frame count: 0 acts as 1, clamp to MAX_FRAMES
  always_comb begin
    fiu32 = 32'(frames_in_use);
    if (fiu32 == 32'd0) begin
      n = NW'(1);
    end else if (fiu32 > MAX_FRAMES) begin
      n = NW'(MAX_FRAMES);
    end else begin
      n = NW'(fiu32);
    end
  end

  assign pg_in   = PW'(32'(virtual_address[15:8]) % PAGE_COUNT);
  assign km1     = k - NW'(1);
  assign fifo_v  = (NW'(frame_nx) < n) ? frame_nx : '0;
  assign frame32 = 32'(frm);
  assign out_free = !result_valid || result_ready;
  assign addr_ready = (state == S_IDLE);

  // parallel TLB compare, lowest matching entry wins
  always_comb begin
    tlb_hit    = 1'b0;
    tlb_hit_fr = '0;
    for (int j = TLB_ENTRIES - 1; j >= 0; j--) begin
      if (tlb_vld[j] && tlb_pg[j] == page_q) begin
        tlb_hit    = 1'b1;
        tlb_hit_fr = tlb_fr[j];
      end
    end
  end

  // RAM port control
  always_comb begin
    pm_raddr  = (state == S_OWN) ? own_rd[PW-1:0] : pg_in;
    pm_we     = 1'b0;
    pm_waddr  = page_q;
    pm_wdata  = '0;
    own_we    = 1'b0;
    own_waddr = frm;
    own_wdata = '0;
    age_we    = 1'b0;
    age_waddr = frm;
    age_wdata = '0;
    case (state)
      S_CLR: begin
        if (32'(clr) < PAGE_COUNT) begin
          pm_we    = 1'b1;
          pm_waddr = clr[PW-1:0];
        end
        if (32'(clr) < MAX_FRAMES) begin
          own_we    = 1'b1;
          own_waddr = clr[FW-1:0];
          age_we    = 1'b1;
          age_waddr = clr[FW-1:0];
          age_wdata = AGE_BITS'(1);
        end
      end
      S_PMCHK: begin
        if (pm_rd[FW] && pm_rd[FW-1:0] == frm) begin
          pm_we    = 1'b1;
          pm_waddr = old_q;
        end
      end
      S_MAP: begin
        pm_we     = 1'b1;
        pm_wdata  = {1'b1, frm};
        own_we    = 1'b1;
        own_wdata = {1'b1, page_q};
        age_we    = 1'b1;
      end
      S_AGEZ: begin
        age_we = 1'b1;
      end
      S_AGEUP: begin
        if (k != '0) begin
          age_we    = 1'b1;
          age_waddr = km1[FW-1:0];
          age_wdata = (age_rd != '1) ? age_rd + AGE_BITS'(1) : age_rd;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (pm_we) begin
      pm_mem[pm_waddr] <= pm_wdata;
    end
    pm_rd <= pm_mem[pm_raddr];
  end

  always_ff @(posedge clk) begin
    if (own_we) begin
      own_mem[own_waddr] <= own_wdata;
    end
    own_rd <= own_mem[frm];
  end

  always_ff @(posedge clk) begin
    if (age_we) begin
      age_mem[age_waddr] <= age_wdata;
    end
    age_rd <= age_mem[k[FW-1:0]];
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_CLR;
      clr           <= '0;
      policy        <= POL_FIFO;
      frames_in_use <= CFG_DATA_W'(FRAMES_RESET);
      tlb_nx        <= '0;
      frame_nx      <= '0;
      hit_cnt       <= '0;
      flt_cnt       <= '0;
      result_valid  <= 1'b0;
      k             <= '0;
      for (int j = 0; j < TLB_ENTRIES; j++) begin
        tlb_vld[j] <= 1'b0;
      end
    end else begin
      if (cfg_write) begin
        if (cfg_index == CFG_POLICY) begin
          policy <= cfg_data[0];
        end else if (cfg_index == CFG_FRAMES) begin
          frames_in_use <= cfg_data;
        end
      end
      // in S_FIN a taken result is replaced by the next one below
      if (result_valid && result_ready && state != S_FIN) begin
        result_valid <= 1'b0;
      end
      case (state)
        S_CLR: begin
          if (32'(clr) == DEPTH - 1) begin
            state <= S_IDLE;
          end else begin
            clr <= clr + CW'(1);
          end
        end
        S_IDLE: begin
          if (addr_valid) begin
            page_q <= pg_in;
            off_q  <= virtual_address[7:0];
            state  <= S_LOOK;
          end
        end
        S_LOOK: begin
          k <= '0;
          if (tlb_hit) begin
            frm   <= tlb_hit_fr;
            outc  <= OUT_TLB_HIT;
            if (hit_cnt != '1) begin
              hit_cnt <= hit_cnt + 32'd1;
            end
            state <= (policy == POL_LRU) ? S_AGEZ : S_FIN;
          end else if (pm_rd[FW]) begin
            frm    <= pm_rd[FW-1:0];
            outc   <= OUT_PT_HIT;
            tlb_vld[tlb_nx] <= 1'b1;
            tlb_pg[tlb_nx]  <= page_q;
            tlb_fr[tlb_nx]  <= pm_rd[FW-1:0];
            tlb_nx <= (32'(tlb_nx) == TLB_ENTRIES - 1) ? '0 : tlb_nx + TW'(1);
            state  <= (policy == POL_LRU) ? S_AGEZ : S_FIN;
          end else begin
            outc <= OUT_FAULT;
            if (flt_cnt != '1) begin
              flt_cnt <= flt_cnt + 32'd1;
            end
            if (policy == POL_LRU) begin
              state <= S_SCAN;
            end else begin
              frm      <= fifo_v;
              frame_nx <= (NW'(fifo_v) + NW'(1) < n) ? fifo_v + FW'(1) : '0;
              state    <= S_VICT;
            end
          end
        end
        S_SCAN: begin
          // read frame k, compare frame k-1
          if (k != '0) begin
            if (k == NW'(1) || age_rd > best) begin
              best <= age_rd;
              frm  <= km1[FW-1:0];
            end
          end
          if (k == n) begin
            state <= S_VICT;
          end else begin
            k <= k + NW'(1);
          end
        end
        S_VICT: begin
          for (int j = 0; j < TLB_ENTRIES; j++) begin
            if (tlb_vld[j] && tlb_fr[j] == frm) begin
              tlb_vld[j] <= 1'b0;
            end
          end
          state <= S_OWN;
        end
        S_OWN: begin
          old_q <= own_rd[PW-1:0];
          state <= own_rd[PW] ? S_PMCHK : S_MAP;
        end
        S_PMCHK: begin
          state <= S_MAP;
        end
        S_MAP: begin
          tlb_vld[tlb_nx] <= 1'b1;
          tlb_pg[tlb_nx]  <= page_q;
          tlb_fr[tlb_nx]  <= frm;
          tlb_nx <= (32'(tlb_nx) == TLB_ENTRIES - 1) ? '0 : tlb_nx + TW'(1);
          k      <= '0;
          state  <= (policy == POL_LRU) ? S_AGEZ : S_FIN;
        end
        S_AGEZ: begin
          k     <= '0;
          state <= S_AGEUP;
        end
        S_AGEUP: begin
          if (k == n) begin
            state <= S_FIN;
          end else begin
            k <= k + NW'(1);
          end
        end
        S_FIN: begin
          if (out_free) begin
            result_valid     <= 1'b1;
            frame_number     <= frame32[7:0];
            physical_address <= {frame32[7:0], off_q};
            outcome          <= outc;
            tlb_hit_count    <= hit_cnt;
            fault_count      <= flt_cnt;
            state            <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/tlbpt_checker.sv
// tlbpt_assert: port-level assertions for tlb_page_table_translator, plus bind.
// Depends on tlbpt_pkg.
`default_nettype none
module tlbpt_assert
  import tlbpt_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        result_valid,
  input wire logic        result_ready,
  input wire logic [7:0]  frame_number,
  input wire logic [15:0] physical_address,
  input wire logic [1:0]  outcome
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(frame_number))
    else $error("result dropped while stalled");

  a_code: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (outcome == OUT_TLB_HIT || outcome == OUT_PT_HIT ||
                      outcome == OUT_FAULT))
    else $error("bad outcome code");

  a_pa: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> physical_address[15:8] == frame_number)
    else $error("physical address disagrees with frame");

  a_rst: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result after reset");

endmodule

bind tlb_page_table_translator tlbpt_assert u_tlbpt_assert (
  .clk              (clk),
  .rst              (rst),
  .result_valid     (result_valid),
  .result_ready     (result_ready),
  .frame_number     (frame_number),
  .physical_address (physical_address),
  .outcome          (outcome)
);
`default_nettype wire
